// ===== rtl/srpl_pkg.sv =====
// ----------------------------------------------------------------------------
// srpl_pkg
// shared widths, register codes, control and status structs and saturation helper
// ----------------------------------------------------------------------------
`default_nettype none

package srpl_pkg;

    localparam int ADDR_W     = 18;
    localparam int DEPTH      = 1 << ADDR_W;
    localparam int FILL_W     = ADDR_W + 1;
    localparam int SMP_W      = 24;
    localparam int LEN_W      = ADDR_W;
    localparam int SPD_W      = 16;
    localparam int GAIN_W     = 16;
    localparam int FRAC_W     = 14;
    localparam int PACC_W     = ADDR_W + FRAC_W + 1;
    localparam int SMOOTH_WIN = 64;
    localparam int SM_SHIFT   = $clog2(SMOOTH_WIN);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam int WIDE_W     = 48;

    localparam logic [CFG_IDX_W-1:0] REG_SPLICE_LEN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RECYCLE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WET        = 3'd4;

    localparam logic [LEN_W-1:0]  RST_SPLICE_LEN = 18'd48000;
    localparam logic [SPD_W-1:0]  RST_SPEED      = 16'd16384;
    localparam logic [GAIN_W-1:0] RST_RECYCLE    = 16'd0;
    localparam logic [GAIN_W-1:0] RST_WET        = 16'd16384;

    localparam logic signed [WIDE_W-1:0] SMP_MAX = 48'sd8388607;
    localparam logic signed [WIDE_W-1:0] SMP_MIN = -48'sd8388608;

    typedef struct packed {
        logic                    start;
        logic                    rev;
        logic [LEN_W-1:0]        len;
        logic [SPD_W-1:0]        speed;
        logic signed [SMP_W-1:0] last;
    } seq_ctrl_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [FILL_W-1:0] fill;
    } seq_stat_t;

    function automatic logic signed [SMP_W-1:0] sat24(input logic signed [WIDE_W-1:0] v);
        logic signed [SMP_W-1:0] r;
        if (v > SMP_MAX)
            r = SMP_MAX[SMP_W-1:0];
        else if (v < SMP_MIN)
            r = SMP_MIN[SMP_W-1:0];
        else
            r = v[SMP_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/srpl_if.sv =====
// ----------------------------------------------------------------------------
// srpl_if
// sample and configuration channels with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface srpl_in_if;
    import srpl_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] in_sample;
    modport source (output valid, output in_sample, input ready);
    modport sink (input valid, input in_sample, output ready);
endinterface

interface srpl_out_if;
    import srpl_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] out_sample;
    modport source (output valid, output out_sample, input ready);
    modport sink (input valid, input out_sample, output ready);
endinterface

interface srpl_cfg_if;
    import srpl_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/srpl_resamp.sv =====
// ----------------------------------------------------------------------------
// srpl_resamp
// splice boundary sequencer: reverse, linear resample and head crossfade
// ----------------------------------------------------------------------------
`default_nettype none

module srpl_resamp (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire srpl_pkg::seq_ctrl_t             ctrl,
    output srpl_pkg::seq_stat_t                  stat,
    output logic                                 rd_en,
    output logic [srpl_pkg::ADDR_W-1:0]          rd_addr,
    input  wire logic signed [srpl_pkg::SMP_W-1:0] rd_data,
    output logic                                 wr_en,
    output logic [srpl_pkg::ADDR_W-1:0]          wr_addr,
    output logic signed [srpl_pkg::SMP_W-1:0]    wr_data
);
    import srpl_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CHK  = 4'd1;
    localparam logic [3:0] S_RDB  = 4'd2;
    localparam logic [3:0] S_MA   = 4'd3;
    localparam logic [3:0] S_MB   = 4'd4;
    localparam logic [3:0] S_SUM  = 4'd5;
    localparam logic [3:0] S_SMA  = 4'd6;
    localparam logic [3:0] S_SMB  = 4'd7;
    localparam logic [3:0] S_WR   = 4'd8;

    logic [3:0]              state_reg, state_next;
    logic [LEN_W-1:0]        len_reg;
    logic [SPD_W-1:0]        spd_reg;
    logic                    rev_reg;
    logic signed [SMP_W-1:0] last_reg;
    logic                    run_reg;
    logic                    done_reg;
    logic [FILL_W-1:0]       i_reg;
    logic [PACC_W-1:0]       p_reg;
    logic [PACC_W-1:0]       pn_reg;
    logic signed [SMP_W-1:0] a_reg;
    logic signed [SMP_W-1:0] b_reg;
    logic signed [39:0]      pa_reg;
    logic signed [39:0]      pb_reg;
    logic signed [SMP_W-1:0] interp_reg;
    logic signed [31:0]      sa_reg;
    logic signed [31:0]      sb_reg;

    logic [PACC_W-1:0]       stop;
    logic [PACC_W-1:0]       lim;
    logic [ADDR_W-1:0]       ip;
    logic [ADDR_W-1:0]       ip1;
    logic [FRAC_W-1:0]       frac;
    logic [FRAC_W:0]         wa;
    logic                    active;
    logic                    in_window;
    logic [SM_SHIFT:0]       wrem;
    logic signed [WIDE_W-1:0] isum;
    logic signed [WIDE_W-1:0] ssum;

    function automatic logic [ADDR_W-1:0] map_addr(input logic rev, input logic [LEN_W-1:0] len,
                                                   input logic [ADDR_W-1:0] j);
        return rev ? (len - ADDR_W'(1) - j) : j;
    endfunction

    always_comb
    begin
        stop      = {1'b0, len_reg - LEN_W'(1), {FRAC_W{1'b0}}};
        lim       = {1'b0, len_reg, {FRAC_W{1'b0}}};
        ip        = p_reg[FRAC_W +: ADDR_W];
        ip1       = ip + ADDR_W'(1);
        frac      = p_reg[FRAC_W-1:0];
        wa        = (FRAC_W+1)'(1 << FRAC_W) - {1'b0, frac};
        in_window = i_reg < FILL_W'(SMOOTH_WIN);
        wrem      = (SM_SHIFT+1)'(SMOOTH_WIN) - {1'b0, i_reg[SM_SHIFT-1:0]};
        // run while len >= 2, read point < stop, next point <= len, output count fits
        active    = run_reg && (len_reg >= LEN_W'(2)) && (p_reg < stop) && (pn_reg <= lim)
                    && (i_reg < FILL_W'(DEPTH));
        isum      = WIDE_W'(pa_reg) + WIDE_W'(pb_reg) + WIDE_W'(1 << (FRAC_W - 1));
        ssum      = WIDE_W'(sa_reg) + WIDE_W'(sb_reg) + WIDE_W'(SMOOTH_WIN / 2);
    end

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = map_addr(rev_reg, len_reg, ip);
        wr_en   = state_reg == S_WR;
        wr_addr = i_reg[ADDR_W-1:0];
        wr_data = in_window ? sat24(ssum >>> SM_SHIFT) : interp_reg;
        case (state_reg)
            S_CHK:
            begin
                rd_en = active;
            end
            S_RDB:
            begin
                rd_en   = 1'b1;
                rd_addr = map_addr(rev_reg, len_reg, ip1);
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (ctrl.start) state_next = S_CHK;
            S_CHK:
            begin
                if (active)
                    state_next = S_RDB;
                else if (in_window)
                    state_next = S_SMA;
                else
                    state_next = S_IDLE;
            end
            S_RDB:  state_next = S_MA;
            S_MA:   state_next = S_MB;
            S_MB:   state_next = S_SUM;
            S_SUM:  state_next = in_window ? S_SMA : S_WR;
            S_SMA:  state_next = S_SMB;
            S_SMB:  state_next = S_WR;
            S_WR:   state_next = S_CHK;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            run_reg   <= 1'b0;
            done_reg  <= 1'b0;
            i_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_CHK) && !active && !in_window;
            if (state_reg == S_IDLE && ctrl.start)
            begin
                run_reg <= 1'b1;
                i_reg   <= '0;
            end
            else if (state_reg == S_CHK && !active)
                run_reg <= 1'b0;
            else if (state_reg == S_WR)
                i_reg <= i_reg + FILL_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (ctrl.start)
                begin
                    len_reg  <= ctrl.len;
                    spd_reg  <= (ctrl.speed == '0) ? SPD_W'(1) : ctrl.speed;
                    rev_reg  <= ctrl.rev;
                    last_reg <= ctrl.last;
                    p_reg    <= '0;
                    pn_reg   <= PACC_W'((ctrl.speed == '0) ? SPD_W'(1) : ctrl.speed);
                end
            end
            S_CHK:  if (!active) interp_reg <= '0;
            S_RDB:  a_reg <= rd_data;
            S_MA:
            begin
                b_reg  <= rd_data;
                pa_reg <= a_reg * $signed({1'b0, wa});
            end
            S_MB:   pb_reg <= b_reg * $signed({2'b0, frac});
            S_SUM:  interp_reg <= sat24(isum >>> FRAC_W);
            S_SMA:  sa_reg <= interp_reg * $signed({1'b0, i_reg[SM_SHIFT-1:0]});
            S_SMB:  sb_reg <= last_reg * $signed({1'b0, wrem});
            S_WR:
            begin
                p_reg  <= pn_reg;
                pn_reg <= pn_reg + PACC_W'(spd_reg);
            end
            default: ;
        endcase
    end

    assign stat.busy = state_reg != S_IDLE;
    assign stat.done = done_reg;
    assign stat.fill = i_reg;

endmodule

`default_nettype wire

// ===== rtl/splice_reverse_pitch_looper.sv =====
// ----------------------------------------------------------------------------
// splice_reverse_pitch_looper
// mono splice looper with recycle, optional reverse and resampled playback
// ----------------------------------------------------------------------------
// A normal sample runs through the step sequencer from accept to result: one
// play store read, then recycle and wet/dry products in steps of their own.
// The sample that starts a new splice first runs the boundary pass over at
// most floor(len * 16384 / speed) resampled words, each needing two cache
// reads on the single read port, a product per read and a sum, plus two
// crossfade products for each of the first 64 words; if fewer words are
// resampled, crossfade-only words fill up to 64. No clearing pass runs after
// reset: the play store is read through a fill count, entries at or above it
// read as zero, and only cache entries of the running splice are ever read back.
`default_nettype none

module splice_reverse_pitch_looper (
    input wire logic   clk,
    input wire logic   rst_n,
    srpl_in_if.sink    feed,
    srpl_out_if.source result,
    srpl_cfg_if.sink   cfg
);
    import srpl_pkg::*;

    localparam logic [3:0] T_IDLE  = 4'd0;
    localparam logic [3:0] T_LAST  = 4'd1;
    localparam logic [3:0] T_LASTW = 4'd2;
    localparam logic [3:0] T_BND   = 4'd3;
    localparam logic [3:0] T_RD    = 4'd4;
    localparam logic [3:0] T_RDW   = 4'd5;
    localparam logic [3:0] T_M1    = 4'd6;
    localparam logic [3:0] T_M2    = 4'd7;
    localparam logic [3:0] T_M3    = 4'd8;
    localparam logic [3:0] T_OUT   = 4'd9;

    logic [LEN_W-1:0]  splice_len_reg;
    logic [SPD_W-1:0]  speed_reg;
    logic              reverse_reg;
    logic [GAIN_W-1:0] recycle_reg;
    logic [GAIN_W-1:0] wet_reg;

    logic [3:0]              state_reg, state_next;
    logic [ADDR_W-1:0]       pos_reg;
    logic [FILL_W-1:0]       fill_reg;
    logic signed [SMP_W-1:0] x_reg;
    logic                    lsel_reg;
    logic                    lfill_reg;
    logic                    pok_reg;
    logic signed [SMP_W-1:0] pv_reg;
    logic signed [40:0]      pr_reg;
    logic signed [40:0]      pm1_reg;
    logic signed [40:0]      pm2_reg;
    logic                    out_valid_reg;
    logic signed [SMP_W-1:0] out_reg;

    logic signed [SMP_W-1:0] cache_mem [DEPTH];
    logic signed [SMP_W-1:0] play_mem [DEPTH];
    logic signed [SMP_W-1:0] cache_rd_reg;
    logic signed [SMP_W-1:0] play_rd_reg;

    logic                    cache_re;
    logic [ADDR_W-1:0]       cache_raddr;
    logic                    cache_we;
    logic signed [SMP_W-1:0] cache_wdata;
    logic                    play_re;
    logic [ADDR_W-1:0]       play_raddr;
    logic signed [SMP_W-1:0] last_val;
    logic signed [16:0]      dry_w;
    logic signed [WIDE_W-1:0] rc_sum;
    logic signed [WIDE_W-1:0] mix_sum;
    logic                    out_load;

    seq_ctrl_t               seq_ctrl;
    seq_stat_t               seq_stat;
    logic                    seq_rd_en;
    logic [ADDR_W-1:0]       seq_rd_addr;
    logic                    seq_wr_en;
    logic [ADDR_W-1:0]       seq_wr_addr;
    logic signed [SMP_W-1:0] seq_wr_data;

    assign cfg.ready  = 1'b1;
    assign feed.ready = state_reg == T_IDLE;
    assign result.valid      = out_valid_reg;
    assign result.out_sample = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            splice_len_reg <= RST_SPLICE_LEN;
            speed_reg      <= RST_SPEED;
            reverse_reg    <= 1'b0;
            recycle_reg    <= RST_RECYCLE;
            wet_reg        <= RST_WET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_SPLICE_LEN: splice_len_reg <= cfg.data[LEN_W-1:0];
                REG_SPEED:      speed_reg      <= cfg.data[SPD_W-1:0];
                REG_REVERSE:    reverse_reg    <= cfg.data[0];
                REG_RECYCLE:    recycle_reg    <= cfg.data[GAIN_W-1:0];
                REG_WET:        wet_reg        <= cfg.data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // cache: written by the step, read by the boundary pass and for the fade source
    always_comb
    begin
        cache_re    = seq_rd_en || (state_reg == T_LAST);
        cache_raddr = seq_stat.busy ? seq_rd_addr : splice_len_reg;
        cache_we    = state_reg == T_M2;
        play_re     = (state_reg == T_LAST) || (state_reg == T_RD);
        play_raddr  = (state_reg == T_LAST) ? splice_len_reg : pos_reg;
        rc_sum      = WIDE_W'(x_reg) + ((WIDE_W'(pr_reg) + WIDE_W'(1 << 14)) >>> 15);
        cache_wdata = sat24(rc_sum);
        mix_sum     = (WIDE_W'(pm1_reg) + WIDE_W'(pm2_reg) + WIDE_W'(1 << 14)) >>> 15;
        dry_w       = 17'sd32768 - $signed({1'b0, wet_reg});
        // fade source: a cache word written this splice, else the play store word, else zero
        if (lsel_reg)
            last_val = cache_rd_reg;
        else if (lfill_reg)
            last_val = play_rd_reg;
        else
            last_val = '0;
        out_load    = (state_reg == T_OUT) && (!out_valid_reg || result.ready);
    end

    always_ff @(posedge clk)
    begin
        if (cache_we)
            cache_mem[pos_reg] <= cache_wdata;
        if (cache_re)
            cache_rd_reg <= cache_mem[cache_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (seq_wr_en)
            play_mem[seq_wr_addr] <= seq_wr_data;
        if (play_re)
            play_rd_reg <= play_mem[play_raddr];
    end

    always_comb
    begin
        seq_ctrl.start = state_reg == T_LASTW;
        seq_ctrl.rev   = reverse_reg;
        seq_ctrl.len   = splice_len_reg;
        seq_ctrl.speed = speed_reg;
        seq_ctrl.last  = last_val;
    end

    srpl_resamp u_resamp (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (seq_ctrl),
        .stat    (seq_stat),
        .rd_en   (seq_rd_en),
        .rd_addr (seq_rd_addr),
        .rd_data (cache_rd_reg),
        .wr_en   (seq_wr_en),
        .wr_addr (seq_wr_addr),
        .wr_data (seq_wr_data)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            T_IDLE:
            begin
                if (feed.valid)
                    state_next = (pos_reg >= splice_len_reg) ? T_LAST : T_RD;
            end
            T_LAST:  state_next = T_LASTW;
            T_LASTW: state_next = T_BND;
            T_BND:   if (seq_stat.done) state_next = T_RD;
            T_RD:    state_next = T_RDW;
            T_RDW:   state_next = T_M1;
            T_M1:    state_next = T_M2;
            T_M2:    state_next = T_M3;
            T_M3:    state_next = T_OUT;
            T_OUT:   if (out_load) state_next = T_IDLE;
            default: state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            pos_reg       <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == T_LASTW)
                pos_reg <= '0;
            else if (out_load)
                pos_reg <= pos_reg + ADDR_W'(1);
            if (state_reg == T_BND && seq_stat.done)
                fill_reg <= seq_stat.fill;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (feed.valid && feed.ready)
            x_reg <= feed.in_sample;
        case (state_reg)
            T_LAST:
            begin
                lsel_reg  <= splice_len_reg < pos_reg;
                lfill_reg <= FILL_W'(splice_len_reg) < fill_reg;
            end
            T_RD:  pok_reg <= FILL_W'(pos_reg) < fill_reg;
            T_RDW: pv_reg  <= pok_reg ? play_rd_reg : '0;
            T_M1:  pr_reg  <= pv_reg * $signed({1'b0, recycle_reg});
            T_M2:  pm1_reg <= x_reg * dry_w;
            T_M3:  pm2_reg <= pv_reg * $signed({1'b0, wet_reg});
            default: ;
        endcase
        if (out_load)
            out_reg <= sat24(mix_sum);
    end

    a_no_accept_in_boundary: assert property (@(posedge clk) disable iff (!rst_n)
        seq_stat.busy |-> !feed.ready)
        else $error("input accepted while boundary pass runs");

    a_no_cache_write_in_boundary: assert property (@(posedge clk) disable iff (!rst_n)
        cache_we |-> !seq_stat.busy)
        else $error("cache written during boundary pass");

    a_result_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == T_OUT)
        else $error("result word raised outside the output step");

    a_pos_cleared_in_boundary: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == T_BND |-> pos_reg == '0)
        else $error("splice position not cleared at boundary");

endmodule

`default_nettype wire
